>>> rtl/mpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_pkg: shared constants, types and arithmetic helpers
// Constants and fixed-point helpers for the complex matrix polynomial block.
// ----------------------------------------------------------------------------
package mpe_pkg;
    localparam int DEF_DIM       = 4;
    localparam int DEF_MAX_BLOCK = 16;
    localparam int DEF_MAX_COEFS = 256;

    localparam logic [1:0] OP_LOAD_MAT  = 2'd0;
    localparam logic [1:0] OP_LOAD_COEF = 2'd1;
    localparam logic [1:0] OP_START     = 2'd2;

    localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
    localparam logic [1:0] REG_BLOCK_COUNT = 2'd1;
    localparam logic [1:0] REG_POLY_DEGREE = 2'd2;

    localparam logic [31:0] FIX_ONE = 32'h0001_0000;

    // Accumulator width: sums of up to 32 rounded products of 48 bits.
    localparam int ACC_W = 56;

    typedef logic signed [ACC_W-1:0] t_acc;

    // Round a Q32.32 product to Q40.16 (add half, floor shift).
    function automatic t_acc round_prod(input logic signed [63:0] prod);
        logic signed [63:0] t;
        begin
            t = prod + 64'sd32768;
            round_prod = t_acc'(t >>> 16);
        end
    endfunction

    function automatic logic [31:0] sat32(input t_acc v);
        begin
            if (v > t_acc'(64'sh7FFF_FFFF)) begin
                sat32 = 32'h7FFF_FFFF;
            end else if (v < -t_acc'(64'sh8000_0000)) begin
                sat32 = 32'h8000_0000;
            end else begin
                sat32 = v[31:0];
            end
        end
    endfunction

    function automatic logic sat_hit(input t_acc v);
        begin
            sat_hit = (v > t_acc'(64'sh7FFF_FFFF)) || (v < -t_acc'(64'sh8000_0000));
        end
    endfunction
endpackage

>>> rtl/matrix_polynomial_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_polynomial_evaluator: complex matrix polynomial, Paterson-Stockmeyer
// Loads a complex matrix and coefficients, then evaluates the polynomial by
// blocked Horner steps on one shared complex multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                      Payload
// command   in         i_start & !o_busy              op,row,col,coef_index,value
// result    out        o_valid (one cycle, no stall)  out_row,out_col,result,flags
// config    in         APB write, pready always high  block_size,block_count,degree
//
// A load passes through one busy state before the next item is taken. A start
// item runs every dot product serially: its terms are issued back to back
// through the shared multiply-accumulate unit, followed by pipeline drain and
// write-back per matrix element, and each Horner step copies its result into
// the result store element by element. Each store has a single read port.
// Reset is synchronous and active low; it clears the controller and the flag and
// loads the configuration defaults. Stores hold no reset state; the result store
// is cleared by the first Horner step, which starts with R = 0 (its product
// terms use zero operands). Results are driven once each and cannot be stalled.
// ----------------------------------------------------------------------------
module matrix_polynomial_evaluator
    import mpe_pkg::*;
#(
    parameter int DIM       = DEF_DIM,
    parameter int MAX_BLOCK = DEF_MAX_BLOCK,
    parameter int MAX_COEFS = DEF_MAX_COEFS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_row,
    input  logic [2:0]  i_col,
    input  logic [7:0]  i_coef_index,
    input  logic signed [31:0] i_value_re,
    input  logic signed [31:0] i_value_im,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        o_valid,
    output logic [2:0]  o_out_row,
    output logic [2:0]  o_out_col,
    output logic signed [31:0] o_result_re,
    output logic signed [31:0] o_result_im,
    output logic        o_saturated,
    output logic        o_last
);
    localparam int ELEMS = DIM * DIM;
    localparam int EW    = (ELEMS > 1) ? $clog2(ELEMS) : 1;
    localparam int DW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int PDEP  = (MAX_BLOCK + 1) * ELEMS;
    localparam int PW    = $clog2(PDEP);
    localparam int CW    = $clog2(MAX_COEFS);
    localparam int BW    = $clog2(MAX_BLOCK + 1);
    localparam int KW    = BW + 1;
    localparam int MDEP  = (ELEMS > 1) ? ELEMS : 2;
    localparam int MAW   = $clog2(MDEP);

    // Sequencer phases.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POW   = 3'd1;
    localparam logic [2:0] S_TSUM  = 3'd2;
    localparam logic [2:0] S_HORN  = 3'd3;
    localparam logic [2:0] S_COPY  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_LOAD  = 3'd6;

    // Per-element sub steps: issue terms, drain the pipeline, then write back.
    localparam logic [1:0] P_ISSUE = 2'd0;
    localparam logic [1:0] P_DRAIN = 2'd1;
    localparam logic [1:0] P_WRITE = 2'd2;

    // ---------------- configuration registers ----------------
    logic [4:0] r_block_size, r_block_count;
    logic [7:0] r_poly_degree;
    logic       cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= 5'd2;
            r_block_count <= 5'd2;
            r_poly_degree <= 8'd3;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BLOCK_SIZE:  r_block_size  <= pwdata[4:0];
                REG_BLOCK_COUNT: r_block_count <= pwdata[4:0];
                REG_POLY_DEGREE: r_poly_degree <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BLOCK_SIZE:  prdata = {27'd0, r_block_size};
            REG_BLOCK_COUNT: prdata = {27'd0, r_block_count};
            REG_POLY_DEGREE: prdata = {24'd0, r_poly_degree};
            default:         prdata = 32'd0;
        endcase
    end

    // Clamped block size and count.
    logic [BW-1:0] p_cl, q_cl;
    always_comb begin
        if (r_block_size == 5'd0) begin
            p_cl = BW'(1);
        end else if (32'(r_block_size) > MAX_BLOCK) begin
            p_cl = BW'(MAX_BLOCK);
        end else begin
            p_cl = BW'(r_block_size);
        end
        if (r_block_count == 5'd0) begin
            q_cl = BW'(1);
        end else if (32'(r_block_count) > MAX_BLOCK) begin
            q_cl = BW'(MAX_BLOCK);
        end else begin
            q_cl = BW'(r_block_count);
        end
    end

    // ---------------- memories ----------------
    logic           mat_we;
    logic [MAW-1:0] mat_wa, mat_ra;
    logic [63:0]    mat_wd, mat_rd;
    logic           coef_we;
    logic [CW-1:0]  coef_wa, coef_ra;
    logic [63:0]    coef_wd, coef_rd;
    logic           pow_we;
    logic [PW-1:0]  pow_wa, pow_ra;
    logic [63:0]    pow_wd, pow_rd;
    logic           tb_we;
    logic [MAW-1:0] tb_wa, tb_ra;
    logic [63:0]    tb_wd, tb_rd;
    logic           res_we;
    logic [MAW-1:0] res_wa, res_ra;
    logic [63:0]    res_wd, res_rd;
    logic           nx_we;
    logic [MAW-1:0] nx_wa, nx_ra;
    logic [63:0]    nx_wd, nx_rd;

    mpe_ram #(.WIDTH(64), .DEPTH(MDEP)) u_mat (
        .i_clk(i_clk), .i_we(mat_we), .i_waddr(mat_wa), .i_wdata(mat_wd),
        .i_raddr(mat_ra), .o_rdata(mat_rd));
    mpe_ram #(.WIDTH(64), .DEPTH(MAX_COEFS)) u_coef (
        .i_clk(i_clk), .i_we(coef_we), .i_waddr(coef_wa), .i_wdata(coef_wd),
        .i_raddr(coef_ra), .o_rdata(coef_rd));
    mpe_ram #(.WIDTH(64), .DEPTH(PDEP)) u_pow (
        .i_clk(i_clk), .i_we(pow_we), .i_waddr(pow_wa), .i_wdata(pow_wd),
        .i_raddr(pow_ra), .o_rdata(pow_rd));
    mpe_ram #(.WIDTH(64), .DEPTH(MDEP)) u_tsum (
        .i_clk(i_clk), .i_we(tb_we), .i_waddr(tb_wa), .i_wdata(tb_wd),
        .i_raddr(tb_ra), .o_rdata(tb_rd));
    mpe_ram #(.WIDTH(64), .DEPTH(MDEP)) u_res (
        .i_clk(i_clk), .i_we(res_we), .i_waddr(res_wa), .i_wdata(res_wd),
        .i_raddr(res_ra), .o_rdata(res_rd));
    mpe_ram #(.WIDTH(64), .DEPTH(MDEP)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd));

    // ---------------- sequencer registers ----------------
    logic [2:0]    r_state, n_state;
    logic [1:0]    r_ph, n_ph;
    logic [KW-1:0] r_k, n_k;        // power index or block index q
    logic [EW:0]   r_e, n_e;        // element index within the matrix
    logic [KW-1:0] r_t, n_t;        // term counter within a dot product
    logic [2:0]    r_dr, n_dr;      // drain counter
    logic          r_first, n_first; // first Horner step: R is zero
    logic          r_flag;

    // Issue-side pipeline tags (aligned with memory read latency).
    logic          r_iv;            // term issued last cycle, data arrives now
    logic          r_iclr;
    logic          r_izero;         // coefficient, or R in the first Horner step, forced to zero

    // Out stage registers.
    logic          r_ov;
    logic [2:0]    r_orow, r_ocol;
    logic          r_olast;

    // Element row and column of r_e.
    logic [DW-1:0] e_row, e_col;
    logic [EW-1:0] e_idx;
    assign e_idx = r_e[EW-1:0];
    assign e_row = (DIM > 1) ? DW'(e_idx / EW'(DIM)) : DW'(0);
    assign e_col = (DIM > 1) ? DW'(e_idx % EW'(DIM)) : DW'(0);

    // Term count of the current dot product.
    logic [KW-1:0] t_len;
    always_comb begin
        case (r_state)
            S_TSUM:  t_len = KW'(p_cl);
            default: t_len = KW'(DIM);
        endcase
    end

    // Coefficient index p*q + k.
    logic [BW+BW:0] cidx_full;
    logic           c_zero;
    assign cidx_full = (BW+BW+1)'(p_cl) * (BW+BW+1)'(r_k) + (BW+BW+1)'(r_t);
    assign c_zero = (cidx_full > (BW+BW+1)'(r_poly_degree)) ||
                    (cidx_full >= (BW+BW+1)'(MAX_COEFS));

    // MAC inputs.
    logic        mac_v, mac_clr;
    t_acc        mac_init_re, mac_init_im;
    logic [31:0] ma_re, ma_im, mb_re, mb_im;
    t_acc        acc_re, acc_im;

    mpe_mac u_mac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(mac_v), .i_clear(mac_clr),
        .i_init_re(mac_init_re), .i_init_im(mac_init_im),
        .i_a_re(ma_re), .i_a_im(ma_im), .i_b_re(mb_re), .i_b_im(mb_im),
        .o_acc_re(acc_re), .o_acc_im(acc_im));

    // Operand selection from data returned by the memories.
    always_comb begin
        mac_v       = r_iv;
        mac_clr     = r_iclr;
        mac_init_re = '0;
        mac_init_im = '0;
        ma_re = 32'd0; ma_im = 32'd0; mb_re = 32'd0; mb_im = 32'd0;
        case (r_state)
            S_POW: begin
                ma_re = pow_rd[63:32]; ma_im = pow_rd[31:0];
                mb_re = mat_rd[63:32]; mb_im = mat_rd[31:0];
            end
            S_TSUM: begin
                ma_re = r_izero ? 32'd0 : coef_rd[63:32];
                ma_im = r_izero ? 32'd0 : coef_rd[31:0];
                mb_re = pow_rd[63:32]; mb_im = pow_rd[31:0];
            end
            S_HORN: begin
                mac_init_re = t_acc'($signed(tb_rd[63:32]));
                mac_init_im = t_acc'($signed(tb_rd[31:0]));
                ma_re = r_izero ? 32'd0 : res_rd[63:32];
                ma_im = r_izero ? 32'd0 : res_rd[31:0];
                mb_re = pow_rd[63:32]; mb_im = pow_rd[31:0];
            end
            default: begin
                mac_v = 1'b0;
            end
        endcase
    end

    // Saturated write-back value.
    logic [63:0] wb_val;
    logic        wb_sat;
    assign wb_val = {sat32(acc_re), sat32(acc_im)};
    assign wb_sat = sat_hit(acc_re) | sat_hit(acc_im);

    logic accept;
    assign accept = i_start & ~o_busy;
    assign o_busy = (r_state != S_IDLE);

    // Matrix index of m*DIM + j and i*DIM + m for the current term.
    logic [DW-1:0] t_m;
    assign t_m = DW'(r_t);
    logic [EW-1:0] idx_im, idx_mj;
    assign idx_im = EW'(e_row) * EW'(DIM) + EW'(t_m);
    assign idx_mj = EW'(t_m) * EW'(DIM) + EW'(e_col);

    logic issuing;
    assign issuing = (r_ph == P_ISSUE) &&
                     (r_state == S_POW || r_state == S_TSUM || r_state == S_HORN);

    always_comb begin
        n_state = r_state; n_ph = r_ph; n_k = r_k; n_e = r_e; n_t = r_t;
        n_dr = r_dr; n_first = r_first;
        mat_we = 1'b0; mat_wa = MAW'(i_row) * MAW'(DIM) + MAW'(i_col);
        mat_wd = {i_value_re, i_value_im}; mat_ra = MAW'(idx_mj);
        coef_we = 1'b0; coef_wa = CW'(i_coef_index); coef_wd = {i_value_re, i_value_im};
        coef_ra = CW'(cidx_full);
        pow_we = 1'b0; pow_wa = '0; pow_wd = wb_val; pow_ra = '0;
        tb_we = 1'b0; tb_wa = MAW'(e_idx); tb_wd = wb_val; tb_ra = MAW'(e_idx);
        res_we = 1'b0; res_wa = MAW'(e_idx); res_wd = nx_rd; res_ra = MAW'(idx_im);
        nx_we = 1'b0; nx_wa = MAW'(e_idx); nx_wd = wb_val; nx_ra = MAW'(e_idx);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_LOAD_MAT: begin
                            mat_we = (32'(i_row) < DIM) && (32'(i_col) < DIM);
                            n_state = S_LOAD;
                        end
                        OP_LOAD_COEF: begin
                            coef_we = (32'(i_coef_index) < MAX_COEFS);
                            n_state = S_LOAD;
                        end
                        OP_START: begin
                            // Powers 0 and 1 are written by the copy pass first.
                            n_state = S_COPY; n_e = '0; n_k = '0;
                        end
                        default: n_state = S_LOAD;
                    endcase
                end
            end
            S_LOAD: n_state = S_IDLE;
            S_COPY: begin
                // Pass 1: write identity and A into powers 0 and 1.
                mat_ra = MAW'(e_idx);
                if (r_ph == P_ISSUE) begin
                    pow_we = 1'b1;
                    pow_wa = PW'(e_idx);
                    pow_wd = {(e_row == e_col) ? FIX_ONE : 32'd0, 32'd0};
                    n_ph = P_DRAIN;
                end else if (r_ph == P_DRAIN) begin
                    pow_we = 1'b1;
                    pow_wa = PW'(ELEMS) + PW'(e_idx);
                    pow_wd = mat_rd;
                    n_ph = P_ISSUE;
                    if (r_e == (EW+1)'(ELEMS - 1)) begin
                        n_e = '0; n_t = '0;
                        if (p_cl >= BW'(2)) begin
                            n_state = S_POW; n_k = KW'(2);
                        end else begin
                            n_state = S_TSUM; n_k = KW'(q_cl) - KW'(1); n_first = 1'b1;
                        end
                    end else begin
                        n_e = r_e + 1'b1;
                    end
                end
            end
            S_POW, S_TSUM, S_HORN: begin
                if (r_state == S_POW) begin
                    pow_ra = PW'(32'(r_k - 1'b1) * ELEMS) + PW'(idx_im);
                end else if (r_state == S_TSUM) begin
                    pow_ra = PW'(32'(r_t) * ELEMS) + PW'(e_idx);
                end else begin
                    pow_ra = PW'(32'(p_cl) * ELEMS) + PW'(idx_mj);
                end
                case (r_ph)
                    P_ISSUE: begin
                        if (r_t == t_len - 1'b1) begin
                            n_t = '0; n_ph = P_DRAIN; n_dr = 3'd0;
                        end else begin
                            n_t = r_t + 1'b1;
                        end
                    end
                    P_DRAIN: begin
                        n_dr = r_dr + 1'b1;
                        if (r_dr == 3'd1) n_ph = P_WRITE;
                    end
                    P_WRITE: begin
                        n_ph = P_ISSUE;
                        if (r_state == S_POW) begin
                            pow_we = 1'b1;
                            pow_wa = PW'(32'(r_k) * ELEMS) + PW'(e_idx);
                        end else if (r_state == S_TSUM) begin
                            tb_we = 1'b1;
                        end else begin
                            nx_we = 1'b1;
                        end
                        if (r_e == (EW+1)'(ELEMS - 1)) begin
                            n_e = '0;
                            if (r_state == S_POW) begin
                                if (r_k == KW'(p_cl)) begin
                                    n_state = S_TSUM; n_k = KW'(q_cl) - KW'(1);
                                    n_first = 1'b1;
                                end else begin
                                    n_k = r_k + 1'b1;
                                end
                            end else if (r_state == S_TSUM) begin
                                n_state = S_HORN;
                            end else begin
                                n_state = S_COPY; n_ph = P_WRITE; n_dr = 3'd0;
                            end
                        end else begin
                            n_e = r_e + 1'b1;
                        end
                    end
                    default: n_ph = P_ISSUE;
                endcase
                // Horner end: copy next into result, reusing COPY in write phase.
            end
            S_OUT: begin
                res_ra = MAW'(e_idx);
                if (r_e == (EW+1)'(ELEMS)) begin
                    n_state = S_IDLE; n_e = '0;
                end else begin
                    n_e = r_e + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Copy pass of next into result, flagged by COPY with P_WRITE phase.
        if (r_state == S_COPY && r_ph == P_WRITE) begin
            pow_we = 1'b0;
            mat_ra = MAW'(e_idx);
            nx_ra  = MAW'(e_idx);
            n_ph = P_WRITE;
            n_state = S_COPY;
            // Read issued at r_dr==0, write at r_dr==1 for the same element.
            if (r_dr == 3'd0) begin
                n_dr = 3'd1;
                n_e  = r_e;
            end else begin
                res_we = 1'b1;
                res_wa = MAW'(e_idx);
                n_dr = 3'd0;
                if (r_e == (EW+1)'(ELEMS - 1)) begin
                    n_e = '0; n_ph = P_ISSUE; n_first = 1'b0;
                    if (r_k == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_TSUM; n_k = r_k - 1'b1;
                    end
                end else begin
                    n_e = r_e + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ph <= P_ISSUE; r_k <= '0; r_e <= '0; r_t <= '0;
            r_dr <= '0; r_first <= 1'b0; r_flag <= 1'b0; r_iv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_ph <= n_ph; r_k <= n_k; r_e <= n_e; r_t <= n_t;
            r_dr <= n_dr; r_first <= n_first;
            r_iv <= issuing;
            if (accept && i_op == OP_START) begin
                r_flag <= 1'b0;
            end else if (r_ph == P_WRITE && (r_state == S_POW || r_state == S_TSUM ||
                         r_state == S_HORN) && wb_sat) begin
                r_flag <= 1'b1;
            end
            // Output stage: read issued at e, data valid the next cycle.
            r_ov <= (r_state == S_OUT) && (r_e != (EW+1)'(ELEMS));
        end
        r_iclr  <= issuing && (r_t == '0);
        r_izero <= (r_state == S_TSUM) ? c_zero : r_first;
        r_orow  <= 3'(e_row);
        r_ocol  <= 3'(e_col);
        r_olast <= (r_e == (EW+1)'(ELEMS - 1));
    end

    assign o_valid     = r_ov;
    assign o_out_row   = r_orow;
    assign o_out_col   = r_ocol;
    assign o_result_re = res_rd[63:32];
    assign o_result_im = res_rd[31:0];
    assign o_saturated = r_flag;
    assign o_last      = r_ov & r_olast;

    // ---------------- assertions ----------------
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy || $past(r_state) == S_OUT)
        else $error("result strobe outside output phase");
    a_last_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !o_valid)
        else $error("result after last element");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_op == OP_START) |=> o_busy)
        else $error("start did not make the block busy");
endmodule

>>> rtl/mpe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_ram: generic single-port-write, registered-read RAM
// One write port and one read port; read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module mpe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/mpe_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_mac: pipelined complex multiply-accumulate unit
// Four real products are registered, rounded and summed into an accumulator.
// ----------------------------------------------------------------------------
module mpe_mac
    import mpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_clear,
    input  t_acc        i_init_re,
    input  t_acc        i_init_im,
    input  logic [31:0] i_a_re,
    input  logic [31:0] i_a_im,
    input  logic [31:0] i_b_re,
    input  logic [31:0] i_b_im,
    output t_acc        o_acc_re,
    output t_acc        o_acc_im
);
    logic              r_v;
    logic              r_clr;
    t_acc              r_init_re;
    t_acc              r_init_im;
    logic signed [63:0] r_rr, r_ii, r_ri, r_ir;
    t_acc              r_acc_re, r_acc_im;
    t_acc              n_base_re, n_base_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_valid;
        end
        r_clr     <= i_clear;
        r_init_re <= i_init_re;
        r_init_im <= i_init_im;
        r_rr <= $signed(i_a_re) * $signed(i_b_re);
        r_ii <= $signed(i_a_im) * $signed(i_b_im);
        r_ri <= $signed(i_a_re) * $signed(i_b_im);
        r_ir <= $signed(i_a_im) * $signed(i_b_re);
    end

    always_comb begin
        n_base_re = r_clr ? r_init_re : r_acc_re;
        n_base_im = r_clr ? r_init_im : r_acc_im;
    end

    always_ff @(posedge i_clk) begin
        if (r_v) begin
            r_acc_re <= n_base_re + round_prod(r_rr) - round_prod(r_ii);
            r_acc_im <= n_base_im + round_prod(r_ri) + round_prod(r_ir);
        end
    end

    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;
endmodule

>>> dv/tb_matrix_polynomial_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_polynomial_evaluator: self-checking bench for the matrix polynomial
// Drives matrix, coefficient and start items through the command port and
// sets the size and degree registers over APB between phases. A scoreboard
// class predicts every result element in Q16.16 complex arithmetic and
// compares it field by field with what the block emits.
// ----------------------------------------------------------------------------
module tb_matrix_polynomial_evaluator;
    import mpe_pkg::*;

    localparam int N     = DEF_DIM;
    localparam int ELEMS = N * N;
    localparam int WATCHDOG_LIMIT = 60000;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } cplx_t;

    typedef struct packed {
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               sat;
        logic               last;
    } elem_t;

    // Scoreboard: mirrors the stores and registers of the block and keeps
    // the result elements that are still owed.
    class poly_scoreboard;
        cplx_t mat [ELEMS];
        cplx_t coef [DEF_MAX_COEFS];
        bit    coef_loaded [DEF_MAX_COEFS];
        cplx_t pw [DEF_MAX_BLOCK + 1][ELEMS];
        logic [4:0] blk_size;
        logic [4:0] blk_count;
        logic [7:0] degree;
        bit    ovf;
        elem_t owed [$];
        int    mismatches;

        function new();
            blk_size   = 5'd2;
            blk_count  = 5'd2;
            degree     = 8'd3;
            mismatches = 0;
            foreach (coef_loaded[i]) coef_loaded[i] = 0;
        endfunction

        function longint rmul(logic signed [31:0] a, logic signed [31:0] b);
            longint t;
            t = longint'(a) * longint'(b) + 64'sd32768;
            return t >>> 16;
        endfunction

        function void mac(inout longint sr, inout longint si, input cplx_t x,
                          input cplx_t y);
            sr += rmul(x.re, y.re) - rmul(x.im, y.im);
            si += rmul(x.re, y.im) + rmul(x.im, y.re);
        endfunction

        function logic signed [31:0] clip(longint v);
            if (v > 64'sd2147483647) begin
                ovf = 1;
                return 32'sh7FFF_FFFF;
            end
            if (v < -64'sd2147483648) begin
                ovf = 1;
                return 32'sh8000_0000;
            end
            return v[31:0];
        endfunction

        function int clamp(logic [4:0] v);
            if (v < 1) return 1;
            if (v > DEF_MAX_BLOCK) return DEF_MAX_BLOCK;
            return int'(v);
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_BLOCK_SIZE:  blk_size  = val[4:0];
                REG_BLOCK_COUNT: blk_count = val[4:0];
                REG_POLY_DEGREE: degree    = val[7:0];
                default: ;
            endcase
        endfunction

        // Runs the blocked Horner evaluation and queues the sixteen elements.
        function void evaluate();
            int p, nb, idx;
            longint sr, si;
            cplx_t acc [ELEMS];
            cplx_t bsum [ELEMS];
            cplx_t nxt [ELEMS];
            cplx_t c;
            elem_t e;
            p   = clamp(blk_size);
            nb  = clamp(blk_count);
            ovf = 0;
            for (int i = 0; i < ELEMS; i++) begin
                pw[0][i].re = (i / N == i % N) ? FIX_ONE : 32'sd0;
                pw[0][i].im = 0;
                pw[1][i]    = mat[i];
                acc[i].re   = 0;
                acc[i].im   = 0;
            end
            for (int k = 2; k <= p; k++) begin
                for (int i = 0; i < N; i++) begin
                    for (int j = 0; j < N; j++) begin
                        sr = 0;
                        si = 0;
                        for (int m = 0; m < N; m++) mac(sr, si, pw[k-1][i*N+m], mat[m*N+j]);
                        pw[k][i*N+j].re = clip(sr);
                        pw[k][i*N+j].im = clip(si);
                    end
                end
            end
            for (int q = nb - 1; q >= 0; q--) begin
                for (int i = 0; i < ELEMS; i++) begin
                    sr = 0;
                    si = 0;
                    for (int k = 0; k < p; k++) begin
                        idx  = p * q + k;
                        c.re = 0;
                        c.im = 0;
                        if (idx <= int'(degree) && idx < DEF_MAX_COEFS) c = coef[idx];
                        mac(sr, si, c, pw[k][i]);
                    end
                    bsum[i].re = clip(sr);
                    bsum[i].im = clip(si);
                end
                for (int i = 0; i < N; i++) begin
                    for (int j = 0; j < N; j++) begin
                        sr = bsum[i*N+j].re;
                        si = bsum[i*N+j].im;
                        for (int m = 0; m < N; m++) mac(sr, si, acc[i*N+m], pw[p][m*N+j]);
                        nxt[i*N+j].re = clip(sr);
                        nxt[i*N+j].im = clip(si);
                    end
                end
                acc = nxt;
            end
            for (int i = 0; i < ELEMS; i++) begin
                e.row  = 3'(i / N);
                e.col  = 3'(i % N);
                e.re   = acc[i].re;
                e.im   = acc[i].im;
                e.sat  = ovf;
                e.last = (i == ELEMS - 1);
                owed.push_back(e);
            end
        endfunction

        // Notes one accepted command item.
        function void note_item(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                                logic [7:0] ci, logic signed [31:0] re,
                                logic signed [31:0] im);
            case (op)
                OP_LOAD_MAT: begin
                    if (row < N && col < N) begin
                        mat[row*N+col].re = re;
                        mat[row*N+col].im = im;
                    end
                end
                OP_LOAD_COEF: begin
                    coef[ci].re     = re;
                    coef[ci].im     = im;
                    coef_loaded[ci] = 1;
                end
                OP_START: evaluate();
                default: ;
            endcase
        endfunction

        // Checks one emitted element against the oldest one owed.
        function void check_result(elem_t got);
            elem_t want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result element row %0d col %0d", got.row, got.col);
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp r%0d c%0d %h %h s%0b l%0b, got r%0d c%0d %h %h s%0b l%0b",
                             want.row, want.col, want.re, want.im, want.sat, want.last,
                             got.row, got.col, got.re, got.im, got.sat, got.last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_op;
    logic [2:0]  i_row;
    logic [2:0]  i_col;
    logic [7:0]  i_coef_index;
    logic signed [31:0] i_value_re;
    logic signed [31:0] i_value_im;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        o_valid;
    logic [2:0]  o_out_row;
    logic [2:0]  o_out_col;
    logic signed [31:0] o_result_re;
    logic signed [31:0] o_result_im;
    logic        o_saturated;
    logic        o_last;

    poly_scoreboard sb;
    bit  gaps_on;
    int  quiet_cycles;

    matrix_polynomial_evaluator dut (.*);

    // 4 ns clock.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Results cannot be stalled, so every strobed element goes straight to
    // the scoreboard. Values are read before the edge's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result('{o_out_row, o_out_col, o_result_re, o_result_im,
                              o_saturated, o_last});
    end

    // The watchdog counts cycles in which neither an item nor a result moved.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (i_start && !o_busy)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // A value that is often small enough to keep the sums in range, sometimes
    // fully random and sometimes an extreme.
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v = 32'sh7FFF_FFFF;
            1: v = 32'sh8000_0000;
            2: v = $urandom_range(0, 1) ? FIX_ONE : 32'sd0;
            3: ;
            default: v = v >>> $urandom_range(12, 31);
        endcase
        return v;
    endfunction

    // Presents one command item and holds it until the block takes it. Start
    // stays high when the next item follows without a gap.
    task automatic send_item(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                             logic [7:0] ci, logic signed [31:0] re,
                             logic signed [31:0] im);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_op         <= op;
        i_row        <= row;
        i_col        <= col;
        i_coef_index <= ci;
        i_value_re   <= re;
        i_value_im   <= im;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_item(op, row, col, ci, re, im);
    endtask

    task automatic release_start();
        i_start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Lets all owed elements drain and the block settle before a write.
    task automatic drain();
        release_start();
        while (sb.owed.size() != 0 || o_busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_sizes(logic [31:0] bs, logic [31:0] bc, logic [31:0] deg);
        drain();
        apb_write(REG_BLOCK_SIZE, bs);
        apb_write(REG_BLOCK_COUNT, bc);
        apb_write(REG_POLY_DEGREE, deg);
        @(posedge i_clk);
    endtask

    // Every coefficient that the next evaluation will read must be loaded.
    task automatic start_eval();
        int top;
        top = sb.clamp(sb.blk_size) * sb.clamp(sb.blk_count) - 1;
        if (top > int'(sb.degree)) top = int'(sb.degree);
        for (int i = 0; i <= top; i++) begin
            if (!sb.coef_loaded[i])
                send_item(OP_LOAD_COEF, 3'($urandom), 3'($urandom), 8'(i),
                          pick_value(), pick_value());
        end
        send_item(OP_START, 3'($urandom), 3'($urandom), 8'($urandom),
                  pick_value(), pick_value());
    endtask

    // Mostly loads with random content followed by a start; some noise.
    task automatic random_items(int count);
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                send_item(OP_LOAD_MAT, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                          8'($urandom), pick_value(), pick_value());
            end else if (kind <= 7) begin
                send_item(OP_LOAD_COEF, 3'($urandom), 3'($urandom),
                          8'($urandom_range(0, 255)), pick_value(), pick_value());
            end else if (kind == 8) begin
                send_item(2'd3, 3'($urandom), 3'($urandom), 8'($urandom),
                          pick_value(), pick_value());
            end else begin
                start_eval();
            end
        end
        start_eval();
    endtask

    initial begin
        sb           = new();
        gaps_on      = 1;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_op         = '0;
        i_row        = '0;
        i_col        = '0;
        i_coef_index = '0;
        i_value_re   = '0;
        i_value_im   = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset sizes: a full matrix with extreme diagonal entries,
        // the four coefficients in use, an unknown op, out-of-range loads.
        for (int i = 0; i < ELEMS; i++)
            send_item(OP_LOAD_MAT, 3'(i / N), 3'(i % N), 8'd0,
                      (i == 0) ? 32'sh7FFF_FFFF : (i == 5) ? 32'sh8000_0000 : pick_value(),
                      (i == 15) ? 32'sh8000_0000 : pick_value());
        send_item(OP_LOAD_COEF, 3'd0, 3'd0, 8'd0, FIX_ONE, 32'sd0);
        send_item(OP_LOAD_COEF, 3'd0, 3'd0, 8'd255, 32'sh7FFF_FFFF, 32'sh8000_0000);
        for (int i = 1; i < 4; i++)
            send_item(OP_LOAD_COEF, 3'd0, 3'd0, 8'(i), pick_value(), pick_value());
        send_item(2'd3, 3'd7, 3'd7, 8'hFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(OP_LOAD_MAT, 3'd7, 3'd2, 8'd0, 32'sh8000_0000, 32'sh8000_0000);
        send_item(OP_LOAD_MAT, 3'd1, 3'd4, 8'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        start_eval();

        // Phases through the size extremes, clamped values included.
        set_sizes(32'd1, 32'd1, 32'd0);
        random_items(8);
        set_sizes(32'd16, 32'd16, 32'd24);
        random_items(4);
        set_sizes(32'd0, 32'd31, 32'd40);
        random_items(8);
        set_sizes(32'hFFFF_FFFF, 32'd0, 32'd7);
        random_items(8);
        set_sizes($urandom, $urandom, $urandom_range(0, 31));
        random_items(10);
        set_sizes($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(0, 16));
        random_items(10);

        // Last part runs back to back.
        gaps_on = 0;
        set_sizes($urandom_range(1, 6), $urandom_range(1, 6), $urandom);
        random_items(10);

        drain();
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
